/* design/pwcap_pkg.sv */
// ----------------------------------------------------------------------------
// Pulse width capture package
// Shared constants and types for the four-channel pulse width capture block.
// ----------------------------------------------------------------------------
`default_nettype none

package pwcap_pkg;

	// Default parameter values.
	localparam int OVERFLOW_BITS_DEF = 6;
	localparam int COUNTER_BITS_DEF  = 16;

	// Fixed port widths.
	localparam int NUM_CHAN  = 4;
	localparam int FIELD_W   = 16;
	localparam int WIDTH_W   = 22;
	localparam logic [WIDTH_W-1:0] WIDTH_MAX = {WIDTH_W{1'b1}};

	// Per-channel status flags reported by a lane.
	typedef struct packed {
		logic done;
		logic armed;
		logic timed_out;
	} lane_stat_t;

endpackage

`default_nettype wire

/* design/four_channel_pulse_width_capture.sv */
// ----------------------------------------------------------------------------
// Four-channel pulse width capture
// Measures high-pulse widths on four timer channels, one lane per channel.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one timer event per request, carrying
// the overflow flag, the capture flags and values, the current counter value
// and the per-channel clear bits. Output channel (out_valid/out_ready): one
// result per event with the done, armed and timeout masks and four widths.
//
// Throughput is one event per cycle while the receiver takes results. The
// lanes update their state when an event is accepted, and the widths and
// masks move into the output register once that register is free.
// The width path is one subtract and one compare per lane.
//
// Reset clears all channel state, so every channel starts idle and reports a
// width of zero. When the receiver stalls, the output register holds its
// result and one further event is still taken into the lanes; after that the
// input is held off until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module four_channel_pulse_width_capture #(
	parameter int OVERFLOW_BITS = pwcap_pkg::OVERFLOW_BITS_DEF,
	parameter int COUNTER_BITS  = pwcap_pkg::COUNTER_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire                                  overflow_event,
	input  wire  [pwcap_pkg::NUM_CHAN-1:0]       capture_flags,
	input  wire  [pwcap_pkg::FIELD_W-1:0]        capture_value_a,
	input  wire  [pwcap_pkg::FIELD_W-1:0]        capture_value_b,
	input  wire  [pwcap_pkg::FIELD_W-1:0]        capture_value_c,
	input  wire  [pwcap_pkg::FIELD_W-1:0]        capture_value_d,
	input  wire  [pwcap_pkg::FIELD_W-1:0]        counter_now,
	input  wire  [pwcap_pkg::NUM_CHAN-1:0]       clear_mask,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic [pwcap_pkg::NUM_CHAN-1:0]       done_mask,
	output logic [pwcap_pkg::NUM_CHAN-1:0]       falling_armed_mask,
	output logic [pwcap_pkg::NUM_CHAN-1:0]       timeout_mask,
	output logic [pwcap_pkg::WIDTH_W-1:0]        width_a,
	output logic [pwcap_pkg::WIDTH_W-1:0]        width_b,
	output logic [pwcap_pkg::WIDTH_W-1:0]        width_c,
	output logic [pwcap_pkg::WIDTH_W-1:0]        width_d
);
	import pwcap_pkg::*;

	logic                                   accept;
	logic [NUM_CHAN-1:0][FIELD_W-1:0]       cap_value;
	lane_stat_t [NUM_CHAN-1:0]              lane_stat;
	logic [NUM_CHAN-1:0][WIDTH_W-1:0]       lane_width;
	logic [NUM_CHAN-1:0][WIDTH_W-1:0]       widths;

	assign accept = in_valid && in_ready;

	assign cap_value[0] = capture_value_a;
	assign cap_value[1] = capture_value_b;
	assign cap_value[2] = capture_value_c;
	assign cap_value[3] = capture_value_d;

	// One lane per channel.
	for (genvar i = 0; i < NUM_CHAN; i++) begin : g_lane
		pwcap_lane #(
			.OVERFLOW_BITS(OVERFLOW_BITS),
			.COUNTER_BITS (COUNTER_BITS)
		) u_lane (
			.clk           (clk),
			.arst_n        (arst_n),
			.update        (accept),
			.overflow_event(overflow_event),
			.capture       (capture_flags[i]),
			.clear         (clear_mask[i]),
			.capture_value (cap_value[i]),
			.counter_now   (counter_now),
			.stat          (lane_stat[i]),
			.width         (lane_width[i])
		);
	end

	// Merge the lane results and drive the output channel.
	pwcap_merge u_merge (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.lane_stat         (lane_stat),
		.lane_width        (lane_width),
		.done_mask         (done_mask),
		.falling_armed_mask(falling_armed_mask),
		.timeout_mask      (timeout_mask),
		.widths            (widths)
	);

	assign width_a = widths[0];
	assign width_b = widths[1];
	assign width_c = widths[2];
	assign width_d = widths[3];

endmodule

`default_nettype wire

/* design/pwcap_lane.sv */
// ----------------------------------------------------------------------------
// Pulse width capture lane
// Holds the capture state of one channel, updates it on each accepted
// request and computes the channel's saturated pulse width.
// ----------------------------------------------------------------------------
`default_nettype none

module pwcap_lane #(
	parameter int OVERFLOW_BITS = 6,
	parameter int COUNTER_BITS  = 16
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   update,
	input  wire                                   overflow_event,
	input  wire                                   capture,
	input  wire                                   clear,
	input  wire  [pwcap_pkg::FIELD_W-1:0]         capture_value,
	input  wire  [pwcap_pkg::FIELD_W-1:0]         counter_now,
	output pwcap_pkg::lane_stat_t                 stat,
	output logic [pwcap_pkg::WIDTH_W-1:0]         width
);
	import pwcap_pkg::*;

	localparam int SUM_W = OVERFLOW_BITS + COUNTER_BITS + 1;
	localparam int CMP_W = (SUM_W - 1 > WIDTH_W) ? SUM_W - 1 : WIDTH_W;

	logic                     done_q, high_q, tout_q;
	logic [OVERFLOW_BITS-1:0] ovf_q;
	logic [COUNTER_BITS-1:0]  end_q, start_q;

	logic                     done_d, high_d, tout_d;
	logic [OVERFLOW_BITS-1:0] ovf_d;
	logic [COUNTER_BITS-1:0]  end_d, start_d;
	logic                     was_done;

	// Next state: clear first, then overflow, then the edge capture.
	always_comb begin
		if (clear) begin
			done_d  = 1'b0;
			high_d  = 1'b0;
			tout_d  = 1'b0;
			ovf_d   = '0;
			end_d   = '0;
			start_d = '0;
		end else begin
			done_d  = done_q;
			high_d  = high_q;
			tout_d  = tout_q;
			ovf_d   = ovf_q;
			end_d   = end_q;
			start_d = start_q;
		end
		was_done = done_d;
		if (!was_done) begin
			if (overflow_event && high_d) begin
				if (&ovf_d) begin
					done_d = 1'b1;
					end_d  = '1;
					tout_d = 1'b1;
				end else begin
					ovf_d = ovf_d + 1'b1;
				end
			end
			if (capture) begin
				if (high_d) begin
					done_d = 1'b1;
					end_d  = COUNTER_BITS'(capture_value);
					tout_d = 1'b0;
				end else begin
					done_d  = 1'b0;
					tout_d  = 1'b0;
					ovf_d   = '0;
					end_d   = '0;
					high_d  = 1'b1;
					start_d = COUNTER_BITS'(counter_now);
				end
			end
		end
	end

	// Control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			high_q <= 1'b0;
			tout_q <= 1'b0;
			ovf_q  <= '0;
		end else if (update) begin
			done_q <= done_d;
			high_q <= high_d;
			tout_q <= tout_d;
			ovf_q  <= ovf_d;
		end
	end

	// Captured counter values; they read as zero after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_q   <= '0;
			start_q <= '0;
		end else if (update) begin
			end_q   <= end_d;
			start_q <= start_d;
		end
	end

	// Width = overflows * 2^COUNTER_BITS + end - start, clamped at both ends.
	logic [SUM_W-1:0] diff;
	logic [CMP_W-1:0] mag;

	assign diff = {1'b0, ovf_q, end_q} - SUM_W'(start_q);
	assign mag  = CMP_W'(diff[SUM_W-2:0]);

	always_comb begin
		if (!done_q || diff[SUM_W-1]) begin
			width = '0;
		end else if (mag > CMP_W'(WIDTH_MAX)) begin
			width = WIDTH_MAX;
		end else begin
			width = WIDTH_W'(mag);
		end
	end

	assign stat.done      = done_q;
	assign stat.armed     = high_q && !done_q;
	assign stat.timed_out = tout_q;

endmodule

`default_nettype wire

/* design/pwcap_merge.sv */
// ----------------------------------------------------------------------------
// Pulse width capture merge stage
// Tracks the request in flight, gathers the lane results into masks and
// holds them in the output register until the receiver takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module pwcap_merge (
	input  wire                                                  clk,
	input  wire                                                  arst_n,
	input  wire                                                  in_valid,
	output logic                                                 in_ready,
	output logic                                                 out_valid,
	input  wire                                                  out_ready,
	input  pwcap_pkg::lane_stat_t [pwcap_pkg::NUM_CHAN-1:0]      lane_stat,
	input  wire  [pwcap_pkg::NUM_CHAN-1:0][pwcap_pkg::WIDTH_W-1:0] lane_width,
	output logic [pwcap_pkg::NUM_CHAN-1:0]                       done_mask,
	output logic [pwcap_pkg::NUM_CHAN-1:0]                       falling_armed_mask,
	output logic [pwcap_pkg::NUM_CHAN-1:0]                       timeout_mask,
	output logic [pwcap_pkg::NUM_CHAN-1:0][pwcap_pkg::WIDTH_W-1:0] widths
);
	import pwcap_pkg::*;

	logic valid_s1;
	logic out_valid_q;
	logic move;

	// The lane state holds the pending result until it moves to the output.
	assign move     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= (in_valid && in_ready) || (valid_s1 && !move);
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register loaded from the lanes.
	always_ff @(posedge clk) begin
		if (move) begin
			for (int i = 0; i < NUM_CHAN; i++) begin
				done_mask[i]          <= lane_stat[i].done;
				falling_armed_mask[i] <= lane_stat[i].armed;
				timeout_mask[i]       <= lane_stat[i].timed_out;
			end
			widths <= lane_width;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
